@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the random generator, included by the top-level unit.
// Every macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define XRG_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/xrg_pkg.sv @@
// Package of the xoshiro256** generator: codes, constants and the
// command and status structs between controller and datapath. No dependencies.
package xrg_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int CMD_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W  = 8;

    localparam logic [WORD_W-1:0] DEF_A  = 64'h0123456789ABCDEF;
    localparam logic [WORD_W-1:0] DEF_B  = 64'hF0E1D2C3B4A59687;
    localparam logic [WORD_W-1:0] DEF_C  = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] DEF_D  = 64'hD1B54A32D192ED03;
    localparam logic [WORD_W-1:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] MIX_M1 = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] MIX_M2 = 64'h94D049BB133111EB;

    // Jump polynomial, word 0 in the low bits; bit i is visited at step i.
    localparam logic [4*WORD_W-1:0] JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT    = 3'd0,
        CMD_BOUNDED = 3'd1,
        CMD_JUMP    = 3'd2,
        CMD_LOAD    = 3'd3,
        CMD_MIX     = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED_VALUE = 3'd0,
        REG_SEED_W0    = 3'd1,
        REG_SEED_W1    = 3'd2,
        REG_SEED_W2    = 3'd3,
        REG_SEED_W3    = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ADV_DRAW,
        DP_DIV_LIMIT,
        DP_DIV_X,
        DP_DIV_STEP,
        DP_JUMP_CLR,
        DP_JUMP_STEP,
        DP_JUMP_COMMIT,
        DP_LOAD_SEEDS,
        DP_MIX_INIT,
        DP_MIX_ADD,
        DP_MUL_LL,
        DP_MUL_HL,
        DP_MUL_LH,
        DP_MIX_FIN
    } t_dp_op;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_ERR,
        OUT_X,
        OUT_REM
    } t_out_src;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NEXT,
        ST_BCHK,
        ST_LIMDIV,
        ST_DRAW,
        ST_TEST,
        ST_MODDIV,
        ST_JCLR,
        ST_JSTEP,
        ST_JCOMMIT,
        ST_LOAD,
        ST_MINIT,
        ST_MADD,
        ST_MLL,
        ST_MHL,
        ST_MLH,
        ST_MFIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic     take;
        t_dp_op   op;
        logic     out_load;
        t_out_src out_src;
    } t_dp_cmd;

    typedef struct packed {
        logic bound_zero;
        logic div_last;
        logic jump_last;
        logic x_below;
        logic mix_second;
        logic mix_last_word;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/xrg_datapath.sv @@
// Datapath of the xoshiro256** generator: state words, seed registers,
// shift-subtract divider, shared 32x32 multiplier and result register. Uses xrg_pkg.
module xrg_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  xrg_pkg::t_dp_cmd                 i_cmd,
    output xrg_pkg::t_dp_sts                 o_sts,
    input  logic [xrg_pkg::WORD_W-1:0]       i_bound,
    input  logic                             i_cfg_we,
    input  logic [xrg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [xrg_pkg::WORD_W-1:0]       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [xrg_pkg::WORD_W-1:0]       o_value,
    output logic                             o_bound_error
);
    import xrg_pkg::*;

    logic [WORD_W-1:0] r_a, r_b, r_c, r_d;
    logic [WORD_W-1:0] r_seed, r_sw0, r_sw1, r_sw2, r_sw3;
    logic [WORD_W-1:0] r_ja, r_jb, r_jc, r_jd;
    logic [WORD_W-1:0] r_bound, r_x, r_limit, r_rem, r_dvd;
    logic [WORD_W-1:0] r_acc, r_z, r_prod;
    logic [HALF_W-1:0] r_cross;
    logic              r_msel;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_value;
    logic              r_err;

    logic [WORD_W-1:0] w_b5, w_rot, w_gen;
    logic [WORD_W-1:0] w_c1, w_d1, w_a1, w_b1, w_c2, w_d2;
    logic [WORD_W:0]   w_trial, w_diff;
    logic [WORD_W-1:0] w_rem_next;
    logic [WORD_W-1:0] w_sum, w_k, w_y;
    logic [HALF_W-1:0] w_mul_a, w_mul_b;
    logic [WORD_W-1:0] w_mul;

    // Output function: rotl(b * 5, 7) * 9, both products as shift-add.
    assign w_b5  = r_b + {r_b[WORD_W-3:0], 2'b00};
    assign w_rot = {w_b5[WORD_W-8:0], w_b5[WORD_W-1:WORD_W-7]};
    assign w_gen = w_rot + {w_rot[WORD_W-4:0], 3'b000};

    assign w_c1 = r_c ^ r_a;
    assign w_d1 = r_d ^ r_b;
    assign w_b1 = r_b ^ w_c1;
    assign w_a1 = r_a ^ w_d1;
    assign w_c2 = w_c1 ^ {r_b[WORD_W-18:0], 17'b0};
    assign w_d2 = {w_d1[18:0], w_d1[WORD_W-1:19]};

    // One restoring division step per cycle; only the remainder is kept.
    assign w_trial    = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff     = w_trial - {1'b0, r_bound};
    assign w_rem_next = w_diff[WORD_W] ? w_trial[WORD_W-1:0] : w_diff[WORD_W-1:0];

    assign w_sum = r_acc + GOLDEN;
    assign w_k   = r_msel ? MIX_M2 : MIX_M1;
    assign w_y   = r_prod + {r_cross, {HALF_W{1'b0}}};

    always_comb begin
        w_mul_a = r_z[HALF_W-1:0];
        w_mul_b = w_k[HALF_W-1:0];
        if (i_cmd.op == DP_MUL_HL) begin
            w_mul_a = r_z[WORD_W-1:HALF_W];
        end
        if (i_cmd.op == DP_MUL_LH) begin
            w_mul_b = w_k[WORD_W-1:HALF_W];
        end
    end
    assign w_mul = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= DEF_A;
            r_b <= DEF_B;
            r_c <= DEF_C;
            r_d <= DEF_D;
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_ADV_DRAW, DP_JUMP_STEP: begin
                    r_a <= w_a1;
                    r_b <= w_b1;
                    r_c <= w_c2;
                    r_d <= w_d2;
                    r_cnt <= r_cnt + 1'b1;
                end
                DP_DIV_LIMIT, DP_DIV_X, DP_JUMP_CLR, DP_MIX_INIT: begin
                    r_cnt <= '0;
                end
                DP_DIV_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                DP_JUMP_COMMIT: begin
                    r_a <= r_ja;
                    r_b <= r_jb;
                    r_c <= r_jc;
                    r_d <= r_jd;
                end
                DP_LOAD_SEEDS: begin
                    r_a <= (r_sw0 != '0) ? r_sw0 : DEF_A;
                    r_b <= (r_sw1 != '0) ? r_sw1 : DEF_B;
                    r_c <= (r_sw2 != '0) ? r_sw2 : DEF_C;
                    r_d <= (r_sw3 != '0) ? r_sw3 : DEF_D;
                end
                DP_MIX_FIN: begin
                    // Finished words shift in from the bottom, so the first lands in a.
                    if (r_msel) begin
                        r_a <= r_b;
                        r_b <= r_c;
                        r_c <= r_d;
                        r_d <= w_y ^ (w_y >> 31);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_sw0  <= '0;
            r_sw1  <= '0;
            r_sw2  <= '0;
            r_sw3  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SEED_VALUE: r_seed <= i_cfg_data;
                REG_SEED_W0:    r_sw0  <= i_cfg_data;
                REG_SEED_W1:    r_sw1  <= i_cfg_data;
                REG_SEED_W2:    r_sw2  <= i_cfg_data;
                REG_SEED_W3:    r_sw3  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_bound <= i_bound;
        end
        unique case (i_cmd.op)
            DP_ADV_DRAW: begin
                r_x     <= w_gen;
                r_limit <= r_rem;
            end
            DP_DIV_LIMIT: begin
                r_rem <= '0;
                r_dvd <= '0 - r_bound;
            end
            DP_DIV_X: begin
                r_rem <= '0;
                r_dvd <= r_x;
            end
            DP_DIV_STEP: begin
                r_rem <= w_rem_next;
                r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            end
            DP_JUMP_CLR: begin
                r_ja <= '0;
                r_jb <= '0;
                r_jc <= '0;
                r_jd <= '0;
            end
            DP_JUMP_STEP: begin
                if (JUMP_POLY[r_cnt]) begin
                    r_ja <= r_ja ^ r_a;
                    r_jb <= r_jb ^ r_b;
                    r_jc <= r_jc ^ r_c;
                    r_jd <= r_jd ^ r_d;
                end
            end
            DP_MIX_INIT: begin
                r_acc <= r_seed;
            end
            DP_MIX_ADD: begin
                r_acc  <= w_sum;
                r_z    <= w_sum ^ (w_sum >> 30);
                r_msel <= 1'b0;
            end
            DP_MUL_LL: begin
                r_prod <= w_mul;
            end
            DP_MUL_HL: begin
                r_cross <= w_mul[HALF_W-1:0];
            end
            DP_MUL_LH: begin
                r_cross <= r_cross + w_mul[HALF_W-1:0];
            end
            DP_MIX_FIN: begin
                if (!r_msel) begin
                    r_z <= w_y ^ (w_y >> 27);
                end
                r_msel <= ~r_msel;
            end
            default: begin
            end
        endcase
    end

    // Result register: it holds a word while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_src)
                OUT_ZERO: begin
                    r_value <= '0;
                    r_err   <= 1'b0;
                end
                OUT_ERR: begin
                    r_value <= '0;
                    r_err   <= 1'b1;
                end
                OUT_X: begin
                    r_value <= r_x;
                    r_err   <= 1'b0;
                end
                OUT_REM: begin
                    r_value <= r_rem;
                    r_err   <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.bound_zero    = (r_bound == '0);
    assign o_sts.div_last      = (r_cnt[5:0] == 6'h3F);
    assign o_sts.jump_last     = (r_cnt == {CNT_W{1'b1}});
    assign o_sts.x_below       = (r_x < r_limit);
    assign o_sts.mix_second    = r_msel;
    assign o_sts.mix_last_word = (r_cnt[1:0] == 2'd3);
    assign o_sts.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_bound_error = r_err;

endmodule

@@ rtl/xrg_ctrl.sv @@
// Controller of the xoshiro256** generator: sequences the datapath for
// each command and loads the result register. Uses xrg_pkg.
module xrg_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [xrg_pkg::CMD_W-1:0]  i_command,
    input  xrg_pkg::t_dp_sts           i_sts,
    output xrg_pkg::t_dp_cmd           o_cmd
);
    import xrg_pkg::*;

    t_state   r_state, n_state;
    t_out_src r_src, n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= OUT_ZERO;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_src         = r_src;
        o_in_ready    = 1'b0;
        o_cmd.take    = 1'b0;
        o_cmd.op      = DP_NOP;
        o_cmd.out_load = 1'b0;
        o_cmd.out_src = r_src;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_command)
                        CMD_NEXT:    n_state = ST_NEXT;
                        CMD_BOUNDED: n_state = ST_BCHK;
                        CMD_JUMP:    n_state = ST_JCLR;
                        CMD_LOAD:    n_state = ST_LOAD;
                        CMD_MIX:     n_state = ST_MINIT;
                        default: begin
                            n_src   = OUT_ZERO;
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_NEXT: begin
                o_cmd.op = DP_ADV_DRAW;
                n_src    = OUT_X;
                n_state  = ST_FIN;
            end
            ST_BCHK: begin
                if (i_sts.bound_zero) begin
                    n_src   = OUT_ERR;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.op = DP_DIV_LIMIT;
                    n_state  = ST_LIMDIV;
                end
            end
            ST_LIMDIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                o_cmd.op = DP_ADV_DRAW;
                n_state  = ST_TEST;
            end
            ST_TEST: begin
                // Draws below the limit are rejected to keep the result unbiased.
                if (i_sts.x_below) begin
                    n_state = ST_DRAW;
                end else begin
                    o_cmd.op = DP_DIV_X;
                    n_state  = ST_MODDIV;
                end
            end
            ST_MODDIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_src   = OUT_REM;
                    n_state = ST_FIN;
                end
            end
            ST_JCLR: begin
                o_cmd.op = DP_JUMP_CLR;
                n_state  = ST_JSTEP;
            end
            ST_JSTEP: begin
                o_cmd.op = DP_JUMP_STEP;
                if (i_sts.jump_last) begin
                    n_state = ST_JCOMMIT;
                end
            end
            ST_JCOMMIT: begin
                o_cmd.op = DP_JUMP_COMMIT;
                n_src    = OUT_ZERO;
                n_state  = ST_FIN;
            end
            ST_LOAD: begin
                o_cmd.op = DP_LOAD_SEEDS;
                n_src    = OUT_ZERO;
                n_state  = ST_FIN;
            end
            ST_MINIT: begin
                o_cmd.op = DP_MIX_INIT;
                n_state  = ST_MADD;
            end
            ST_MADD: begin
                o_cmd.op = DP_MIX_ADD;
                n_state  = ST_MLL;
            end
            ST_MLL: begin
                o_cmd.op = DP_MUL_LL;
                n_state  = ST_MHL;
            end
            ST_MHL: begin
                o_cmd.op = DP_MUL_HL;
                n_state  = ST_MLH;
            end
            ST_MLH: begin
                o_cmd.op = DP_MUL_LH;
                n_state  = ST_MFIN;
            end
            ST_MFIN: begin
                o_cmd.op = DP_MIX_FIN;
                if (!i_sts.mix_second) begin
                    n_state = ST_MLL;
                end else if (i_sts.mix_last_word) begin
                    n_src   = OUT_ZERO;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MADD;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/xoshiro256_random_generator_unit.sv @@
// xoshiro256** random generator unit, 256 bits of state, one result word per command.
// Input channel (i_in_valid/o_in_ready) carries i_command and i_bound; output channel
// (o_out_valid/i_out_ready) returns o_value and o_bound_error, one word per command.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes the seed registers and is always
// ready; the user must use it only while the unit is idle, which the unit does not enforce.
// Index 0 is the splitmix seed, indexes 1 to 4 the direct seed words; others are ignored.
// Commands are processed one at a time by a controller that steps a datapath.
// A bounded command runs two 64-step remainder divisions and draws again after every
// rejected draw; a zero bound skips the divisions and returns the error word.
// A new command is accepted as soon as the controller is back in idle,
// while an earlier word may still sit in the result register.
// When the receiver stalls, the word holds in the result register and a finished
// second command waits in the controller until that register is free.
// Reset (synchronous, active low) loads the default state words and clears the seeds.
// Uses xrg_pkg, xrg_ctrl, xrg_datapath and assert_macros.svh.
module xoshiro256_random_generator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [xrg_pkg::CMD_W-1:0]        i_command,
    input  logic [xrg_pkg::WORD_W-1:0]       i_bound,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [xrg_pkg::WORD_W-1:0]       o_value,
    output logic                             o_bound_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [xrg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [xrg_pkg::WORD_W-1:0]       i_cfg_data
);
    import xrg_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    xrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    xrg_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_bound       (i_bound),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_bound_error (o_bound_error)
    );

`include "assert_macros.svh"

    `XRG_ASSERT_IMPLY(a_err_val, o_out_valid && o_bound_error, o_value == '0, "bad error word")
    `XRG_ASSERT_IMPLY(a_load_when_free, w_cmd.out_load, w_sts.out_free, "result overwritten")
    `XRG_ASSERT_NEXT(a_busy, i_in_valid && o_in_ready, !o_in_ready, "accepted while busy")

endmodule
